### sv/acp_pkg.sv
// ----------------------------------------------------------------------------
// acp_pkg: shared types and codes for the arc closest-point block
// Payload structs, arithmetic widths, region codes and register indexes.
// ----------------------------------------------------------------------------
package acp_pkg;

  localparam int COORD_W = 24;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int ROOT_W  = PROD_W / 2;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  typedef struct packed {
    coord_t query_x;
    coord_t query_y;
  } query_t;

  typedef struct packed {
    coord_t     closest_x;
    coord_t     closest_y;
    logic [1:0] region;
    logic       backfacing;
  } result_t;

  // Per-item control that rides along the long arithmetic stages.
  typedef struct packed {
    coord_t     qx;
    coord_t     qy;
    logic [1:0] vert;
    logic       center;
    logic       sneg;
  } side_t;

  localparam logic [1:0] REGION_START  = 2'd0;
  localparam logic [1:0] REGION_END    = 2'd1;
  localparam logic [1:0] REGION_ARC    = 2'd2;
  localparam logic [1:0] REGION_CENTER = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_END_X    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_END_Y    = 3'd5;

endpackage

### sv/acp_isqrt.sv
// ----------------------------------------------------------------------------
// acp_isqrt: pipelined dual integer square root
// Two radicands, one root bit per stage, truncating; a sideband rides along.
// ----------------------------------------------------------------------------
module acp_isqrt #(
  parameter int IN_W   = 50,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [IN_W-1:0]   n_a,
  input  logic [IN_W-1:0]   n_b,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [IN_W/2-1:0] root_a,
  output logic [IN_W/2-1:0] root_b,
  output logic [SIDE_W-1:0] side_out
);

  localparam int OUT_W = IN_W / 2;
  localparam int REM_W = OUT_W + 2;
  localparam int TRY_W = REM_W + 2;

  logic [IN_W-1:0]   nq      [2][OUT_W];
  logic [OUT_W-1:0]  rt      [2][OUT_W];
  logic [REM_W-1:0]  rm      [2][OUT_W];
  logic [IN_W-1:0]   nq_next [2][OUT_W];
  logic [OUT_W-1:0]  rt_next [2][OUT_W];
  logic [REM_W-1:0]  rm_next [2][OUT_W];
  logic              vld     [OUT_W];
  logic [SIDE_W-1:0] sd      [OUT_W];
  logic [IN_W-1:0]   n_in    [2];

  assign n_in[0] = n_a;
  assign n_in[1] = n_b;

  // Each stage brings down two radicand bits and decides one root bit.
  always_comb begin
    logic [IN_W-1:0]  n_cur;
    logic [OUT_W-1:0] r_cur;
    logic [REM_W-1:0] m_cur;
    logic [TRY_W-1:0] t;
    logic [TRY_W-1:0] trial;
    for (int k = 0; k < OUT_W; k++) begin
      for (int l = 0; l < 2; l++) begin
        if (k == 0) begin
          n_cur = n_in[l];
          r_cur = '0;
          m_cur = '0;
        end else begin
          n_cur = nq[l][k-1];
          r_cur = rt[l][k-1];
          m_cur = rm[l][k-1];
        end
        t     = {m_cur, n_cur[IN_W-1 -: 2]};
        trial = {{(TRY_W-OUT_W-2){1'b0}}, r_cur, 2'b01};
        nq_next[l][k] = n_cur << 2;
        if (t >= trial) begin
          rt_next[l][k] = {r_cur[OUT_W-2:0], 1'b1};
          rm_next[l][k] = REM_W'(t - trial);
        end else begin
          rt_next[l][k] = {r_cur[OUT_W-2:0], 1'b0};
          rm_next[l][k] = t[REM_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < OUT_W; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 1; k < OUT_W; k++) vld[k] <= vld[k-1];
    end
    if (en) begin
      sd[0] <= side_in;
      for (int k = 1; k < OUT_W; k++) sd[k] <= sd[k-1];
      for (int k = 0; k < OUT_W; k++) begin
        for (int l = 0; l < 2; l++) begin
          nq[l][k] <= nq_next[l][k];
          rt[l][k] <= rt_next[l][k];
          rm[l][k] <= rm_next[l][k];
        end
      end
    end
  end

  assign out_valid = vld[OUT_W-1];
  assign root_a    = rt[0][OUT_W-1];
  assign root_b    = rt[1][OUT_W-1];
  assign side_out  = sd[OUT_W-1];

endmodule

### sv/acp_div.sv
// ----------------------------------------------------------------------------
// acp_div: pipelined dual restoring divider
// Two dividends over one shared divisor, one quotient bit per stage.
// ----------------------------------------------------------------------------
module acp_div #(
  parameter int NUM_W  = 50,
  parameter int Q_W    = 25,
  parameter int SIDE_W = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [NUM_W-1:0]     num_a,
  input  logic [NUM_W-1:0]     num_b,
  input  logic [NUM_W-Q_W-1:0] den,
  input  logic [SIDE_W-1:0]    side_in,
  output logic                 out_valid,
  output logic [Q_W-1:0]       quo_a,
  output logic [Q_W-1:0]       quo_b,
  output logic [SIDE_W-1:0]    side_out
);

  localparam int DEN_W = NUM_W - Q_W;

  logic [Q_W-1:0]    lo      [2][Q_W];
  logic [Q_W-1:0]    qq      [2][Q_W];
  logic [DEN_W-1:0]  rm      [2][Q_W];
  logic [Q_W-1:0]    lo_next [2][Q_W];
  logic [Q_W-1:0]    qq_next [2][Q_W];
  logic [DEN_W-1:0]  rm_next [2][Q_W];
  logic [DEN_W-1:0]  dv      [Q_W];
  logic              vld     [Q_W];
  logic [SIDE_W-1:0] sd      [Q_W];
  logic [NUM_W-1:0]  num_in  [2];

  assign num_in[0] = num_a;
  assign num_in[1] = num_b;

  // The upper half of the dividend is already below the divisor, so only
  // the lower Q_W bits need a step each.
  always_comb begin
    logic [Q_W-1:0]   l_cur;
    logic [Q_W-1:0]   q_cur;
    logic [DEN_W-1:0] m_cur;
    logic [DEN_W-1:0] d_cur;
    logic [DEN_W:0]   t;
    for (int k = 0; k < Q_W; k++) begin
      for (int l = 0; l < 2; l++) begin
        if (k == 0) begin
          l_cur = num_in[l][Q_W-1:0];
          q_cur = '0;
          m_cur = num_in[l][NUM_W-1:Q_W];
          d_cur = den;
        end else begin
          l_cur = lo[l][k-1];
          q_cur = qq[l][k-1];
          m_cur = rm[l][k-1];
          d_cur = dv[k-1];
        end
        t = {m_cur, l_cur[Q_W-1]};
        lo_next[l][k] = l_cur << 1;
        if (t >= {1'b0, d_cur}) begin
          qq_next[l][k] = {q_cur[Q_W-2:0], 1'b1};
          rm_next[l][k] = DEN_W'(t - {1'b0, d_cur});
        end else begin
          qq_next[l][k] = {q_cur[Q_W-2:0], 1'b0};
          rm_next[l][k] = t[DEN_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < Q_W; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 1; k < Q_W; k++) vld[k] <= vld[k-1];
    end
    if (en) begin
      sd[0] <= side_in;
      dv[0] <= den;
      for (int k = 1; k < Q_W; k++) begin
        sd[k] <= sd[k-1];
        dv[k] <= dv[k-1];
      end
      for (int k = 0; k < Q_W; k++) begin
        for (int l = 0; l < 2; l++) begin
          lo[l][k] <= lo_next[l][k];
          qq[l][k] <= qq_next[l][k];
          rm[l][k] <= rm_next[l][k];
        end
      end
    end
  end

  assign out_valid = vld[Q_W-1];
  assign quo_a     = qq[0][Q_W-1];
  assign quo_b     = qq[1][Q_W-1];
  assign side_out  = sd[Q_W-1];

endmodule

### sv/arc_closest_point_backface.sv
// ----------------------------------------------------------------------------
// arc_closest_point_backface: closest point on a circular arc
// Classifies a query against the arc by cross-product signs, projects it
// radially in the interior case and reports the back-side flag.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake              | beat
//   ---------+-----------+------------------------+--------------------------
//   query    | in        | query_valid/query_stall| query_x, query_y
//   result   | out       | result_valid/result_st.| closest_x/y, region, back
//   cfg      | in        | cfg_we                 | cfg_index, cfg_data
//
// One beat enters per cycle while query_stall is low.
// The pipeline is built around the two bit-per-stage units: the square root
// (25 stages) and the divider (25 stages), plus seven single stages.
// Reset is synchronous and clears all valid bits and the configuration registers to zero.
// A stall on a valid result freezes the whole pipeline, and query_stall
// rises in the same cycle, so no beat is lost or repeated.
//
module arc_closest_point_backface (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           query_valid,
  output logic                           query_stall,
  input  acp_pkg::query_t                query,
  output logic                           result_valid,
  input  logic                           result_stall,
  output acp_pkg::result_t               result,
  input  logic                           cfg_we,
  input  logic [acp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [acp_pkg::COORD_W-1:0]    cfg_data
);

  import acp_pkg::*;

  localparam int SQ_SIDE_W  = $bits(side_t) + 2 * DIFF_W;
  localparam int DIV_SIDE_W = $bits(side_t) + 2;

  function automatic diff_t sub(coord_t a, coord_t b);
    return {a[COORD_W-1], a} - {b[COORD_W-1], b};
  endfunction

  function automatic sum_t wide(prod_t p);
    return {p[PROD_W-1], p};
  endfunction

  function automatic logic is_pos(sum_t v);
    return !v[SUM_W-1] && (v != '0);
  endfunction

  // Configuration registers. Writes are to be made only while the pipe is empty; the block does not enforce this.
  coord_t center_x, center_y, start_x, start_y, end_x, end_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      start_x  <= '0;
      start_y  <= '0;
      end_x    <= '0;
      end_y    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CENTER_X: center_x <= cfg_data;
        CFG_CENTER_Y: center_y <= cfg_data;
        CFG_START_X:  start_x  <= cfg_data;
        CFG_START_Y:  start_y  <= cfg_data;
        CFG_END_X:    end_x    <= cfg_data;
        CFG_END_Y:    end_y    <= cfg_data;
        default: ;
      endcase
    end
  end

  // The whole pipe moves together unless a finished result is held.
  logic en;
  assign en          = !result_valid || !result_stall;
  assign query_stall = !en;

  // The arc vectors depend only on configuration and are shared by stages.
  diff_t v0x, v0y, v1x, v1y, vx, vy;
  assign v0x = sub(start_x, center_x);
  assign v0y = sub(start_y, center_y);
  assign v1x = sub(end_x, center_x);
  assign v1y = sub(end_y, center_y);
  assign vx  = sub(end_x, start_x);
  assign vy  = sub(end_y, start_y);

  // Stage 1: input register.
  logic   s1_valid;
  query_t s1_q;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (en) s1_valid <= query_valid;
    if (en) s1_q <= query;
  end

  // Stage 2: all products for the region tests and the two radicands.
  diff_t dx1, dy1;
  assign dx1 = sub(s1_q.query_x, center_x);
  assign dy1 = sub(s1_q.query_y, center_y);

  logic   s2_valid;
  query_t s2_q;
  diff_t  s2_dx, s2_dy;
  prod_t  p_d0a, p_d0b, p_v0a, p_v0b, p_d1a, p_d1b, p_v1a, p_v1b;
  prod_t  p_dva, p_dvb, p_sxx, p_syy, p_dxx, p_dyy;

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else if (en) s2_valid <= s1_valid;
    if (en) begin
      s2_q  <= s1_q;
      s2_dx <= dx1;
      s2_dy <= dy1;
      p_d0a <= dy1 * v0x;
      p_d0b <= dx1 * v0y;
      p_v0a <= vy * v0x;
      p_v0b <= vx * v0y;
      p_d1a <= dy1 * v1x;
      p_d1b <= dx1 * v1y;
      p_v1a <= vy * v1x;
      p_v1b <= vx * v1y;
      p_dva <= dx1 * vx;
      p_dvb <= dy1 * vy;
      p_sxx <= v0x * v0x;
      p_syy <= v0y * v0y;
      p_dxx <= dx1 * dx1;
      p_dyy <= dy1 * dy1;
    end
  end

  // Stage 3: signs of the cross and dot products decide the region.
  // cv0 and cv1 are (end - start) crossed with the endpoint normals; when
  // positive, the endpoint backface test flips direction.
  sum_t cd0, cv0, cd1, cv1, dotv;
  logic in0, in1, ctr3;
  logic [1:0] vert3;
  side_t side3;
  logic [PROD_W-1:0] nr3, nd3;

  always_comb begin
    cd0  = wide(p_d0a) - wide(p_d0b);
    cv0  = wide(p_v0a) - wide(p_v0b);
    cd1  = wide(p_d1a) - wide(p_d1b);
    cv1  = wide(p_v1a) - wide(p_v1b);
    dotv = wide(p_dva) + wide(p_dvb);
    in0  = (cd0 == '0) || (cv0 == '0) || (cd0[SUM_W-1] != cv0[SUM_W-1]);
    in1  = (cd1 == '0) || (cv1 == '0) || (cd1[SUM_W-1] == cv1[SUM_W-1]);
    ctr3 = (s2_dx == '0) && (s2_dy == '0);
    if (in0) vert3 = (in1 && is_pos(dotv)) ? REGION_END : REGION_START;
    else     vert3 = in1 ? REGION_END : REGION_ARC;
    if (ctr3) vert3 = REGION_START;
    side3.qx     = s2_q.query_x;
    side3.qy     = s2_q.query_y;
    side3.vert   = vert3;
    side3.center = ctr3;
    side3.sneg   = (vert3 == REGION_END) ? is_pos(cv1) : is_pos(cv0);
    // Squares are below 2^(PROD_W-2), so dropping the sign bit is exact.
    nr3 = {1'b0, p_sxx[PROD_W-2:0]} + {1'b0, p_syy[PROD_W-2:0]};
    nd3 = {1'b0, p_dxx[PROD_W-2:0]} + {1'b0, p_dyy[PROD_W-2:0]};
  end

  logic              s3_valid;
  logic [PROD_W-1:0] s3_nr, s3_nd;
  logic [SQ_SIDE_W-1:0] s3_side;

  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else if (en) s3_valid <= s2_valid;
    if (en) begin
      s3_nr   <= nr3;
      s3_nd   <= nd3;
      s3_side <= {side3, s2_dx, s2_dy};
    end
  end

  // Radius of the arc and length of the query offset.
  logic              sq_valid;
  logic [ROOT_W-1:0] rad, dl;
  logic [SQ_SIDE_W-1:0] sq_side;
  side_t sq_s;
  diff_t sq_dx, sq_dy;

  acp_isqrt #(
    .IN_W   (PROD_W),
    .SIDE_W (SQ_SIDE_W)
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s3_valid),
    .n_a       (s3_nr),
    .n_b       (s3_nd),
    .side_in   (s3_side),
    .out_valid (sq_valid),
    .root_a    (rad),
    .root_b    (dl),
    .side_out  (sq_side)
  );

  assign {sq_s, sq_dx, sq_dy} = sq_side;

  // Stage M: magnitude of each offset component times the radius.
  logic [DIFF_W-1:0] mag_x, mag_y;
  assign mag_x = sq_dx[DIFF_W-1] ? DIFF_W'(-sq_dx) : DIFF_W'(sq_dx);
  assign mag_y = sq_dy[DIFF_W-1] ? DIFF_W'(-sq_dy) : DIFF_W'(sq_dy);

  logic              m_valid;
  logic [PROD_W-1:0] m_nx, m_ny;
  logic [ROOT_W-1:0] m_dl;
  logic [DIV_SIDE_W-1:0] m_side;

  always_ff @(posedge clk) begin
    if (rst) m_valid <= 1'b0;
    else if (en) m_valid <= sq_valid;
    if (en) begin
      m_nx   <= mag_x * rad;
      m_ny   <= mag_y * rad;
      m_dl   <= dl;
      m_side <= {sq_s, sq_dx[DIFF_W-1], sq_dy[DIFF_W-1]};
    end
  end

  // Offset = |d| * radius / dlen, truncated; the quotient never exceeds
  // the radius, so ROOT_W bits hold it.
  logic              dv_valid;
  logic [ROOT_W-1:0] quo_x, quo_y;
  logic [DIV_SIDE_W-1:0] dv_side;
  side_t dv_s;
  logic  dv_nx, dv_ny;

  acp_div #(
    .NUM_W  (PROD_W),
    .Q_W    (ROOT_W),
    .SIDE_W (DIV_SIDE_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (m_valid),
    .num_a     (m_nx),
    .num_b     (m_ny),
    .den       (m_dl),
    .side_in   (m_side),
    .out_valid (dv_valid),
    .quo_a     (quo_x),
    .quo_b     (quo_y),
    .side_out  (dv_side)
  );

  assign {dv_s, dv_nx, dv_ny} = dv_side;

  // Stage F: signed offset plus center, saturated, then pick the point.
  function automatic coord_t place(coord_t c, logic [ROOT_W-1:0] q, logic neg);
    logic signed [ROOT_W:0]    off;
    logic signed [COORD_W+2:0] s;
    off = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    s   = {{3{c[COORD_W-1]}}, c} + {{(COORD_W+2-ROOT_W){off[ROOT_W]}}, off};
    if (s[COORD_W+2:COORD_W-1] == '0 || s[COORD_W+2:COORD_W-1] == '1)
      return s[COORD_W-1:0];
    else if (s[COORD_W+2])
      return {1'b1, {(COORD_W-1){1'b0}}};
    else
      return {1'b0, {(COORD_W-1){1'b1}}};
  endfunction

  coord_t clx_f, cly_f;

  always_comb begin
    case (dv_s.vert)
      REGION_START: begin
        clx_f = start_x;
        cly_f = start_y;
      end
      REGION_END: begin
        clx_f = end_x;
        cly_f = end_y;
      end
      default: begin
        clx_f = place(center_x, quo_x, dv_nx);
        cly_f = place(center_y, quo_y, dv_ny);
      end
    endcase
  end

  logic   f_valid;
  coord_t f_clx, f_cly;
  side_t  f_s;

  always_ff @(posedge clk) begin
    if (rst) f_valid <= 1'b0;
    else if (en) f_valid <= dv_valid;
    if (en) begin
      f_clx <= clx_f;
      f_cly <= cly_f;
      f_s   <= dv_s;
    end
  end

  // Stage B: products for the backface test. Interior uses the cross of
  // (closest - query) with the chord; endpoints use the dot with the
  // endpoint normal.
  diff_t tx, ty, nx, ny;
  logic  arc_b;
  assign tx    = sub(f_clx, f_s.qx);
  assign ty    = sub(f_cly, f_s.qy);
  assign nx    = (f_s.vert == REGION_END) ? v1x : v0x;
  assign ny    = (f_s.vert == REGION_END) ? v1y : v0y;
  assign arc_b = (f_s.vert == REGION_ARC);

  logic   b_valid, b_arc, b_sneg;
  prod_t  b_p1, b_p2;
  coord_t b_clx, b_cly;
  logic [1:0] b_region;

  always_ff @(posedge clk) begin
    if (rst) b_valid <= 1'b0;
    else if (en) b_valid <= f_valid;
    if (en) begin
      b_p1     <= arc_b ? ty * vx : tx * nx;
      b_p2     <= arc_b ? tx * vy : ty * ny;
      b_arc    <= arc_b;
      b_sneg   <= f_s.sneg;
      b_clx    <= f_clx;
      b_cly    <= f_cly;
      b_region <= f_s.center ? REGION_CENTER : f_s.vert;
    end
  end

  // Stage O: final sign and the output register.
  sum_t bs;
  logic back_o;
  assign bs     = b_arc ? wide(b_p1) - wide(b_p2) : wide(b_p1) + wide(b_p2);
  assign back_o = (b_arc || !b_sneg) ? is_pos(bs) : bs[SUM_W-1];

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else if (en) result_valid <= b_valid;
    if (en) begin
      result.closest_x  <= b_clx;
      result.closest_y  <= b_cly;
      result.region     <= b_region;
      result.backfacing <= back_o;
    end
  end

`ifndef SYNTHESIS
  // Endpoint and center results report the configured endpoint exactly.
  a_start_point: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.region == REGION_START || result.region == REGION_CENTER)
    |-> result.closest_x == start_x && result.closest_y == start_y)
    else $error("endpoint 0 result does not match start point");

  a_end_point: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.region == REGION_END
    |-> result.closest_x == end_x && result.closest_y == end_y)
    else $error("endpoint 1 result does not match end point");

  // An interior query is never at the center, so its length is nonzero.
  a_nonzero_len: assert property (@(posedge clk) disable iff (rst)
    sq_valid && sq_s.vert == REGION_ARC |-> dl != '0)
    else $error("interior query reached divider with zero length");

  // A center query always travels as an endpoint 0 item.
  a_center_vert: assert property (@(posedge clk) disable iff (rst)
    f_valid && f_s.center |-> f_s.vert == REGION_START)
    else $error("center query not classified as endpoint 0");
`endif

endmodule

### tb/arc_closest_point_backface_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_closest_point_backface_test: self-checking bench for the arc block
// Streams query beats through the closest-point pipeline under several arc
// settings, with random gaps and stalls on both sides. Each result beat is
// checked field by field against a bit-exact predictor kept in the bench.
// ----------------------------------------------------------------------------
module arc_closest_point_backface_test;
  import acp_pkg::*;

  localparam int  CYCLE_LIMIT = 600000;
  localparam int  DRAIN_WAIT  = 80;     // a little above the pipeline depth
  localparam longint CMAX = 64'sd8388607;
  localparam longint CMIN = -64'sd8388608;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    query_valid = 1'b0;
  logic    query_stall;
  query_t  query = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;
  logic    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COORD_W-1:0]   cfg_data = '0;

  arc_closest_point_backface i_dut (
    .clk(clk), .rst(rst),
    .query_valid(query_valid), .query_stall(query_stall), .query(query),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Bench copy of the arc registers, indexed like the block's registers.
  coord_t  arc_reg [6];
  query_t  query_backlog[$];   // queries waiting for the driver
  result_t closest_due[$];     // predicted results, oldest first
  int      fail_count = 0;
  int      queries_sent = 0;
  int      points_checked = 0;
  int      region_seen [4];
  longint  cycle_count = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  // Sign helpers. The operands never exceed 25 bits, so every product and
  // sum fits comfortably in 64 bits and is exact.
  function automatic int cross_sgn(longint ax, longint ay, longint bx, longint by);
    longint p;
    p = ay * bx - ax * by;
    return (p > 0) ? 1 : ((p < 0) ? -1 : 0);
  endfunction

  function automatic int dot_sgn(longint ax, longint ay, longint bx, longint by);
    longint p;
    p = ax * bx + ay * by;
    return (p > 0) ? 1 : ((p < 0) ? -1 : 0);
  endfunction

  // Truncating square root; the argument stays below 2^50.
  function automatic longint floor_root(longint n);
    longint r, c;
    r = 0;
    for (int b = 25; b >= 0; b--) begin
      c = r | (64'sd1 << b);
      if (c * c <= n) r = c;
    end
    return r;
  endfunction

  function automatic longint clamp_coord(longint v);
    return (v > CMAX) ? CMAX : ((v < CMIN) ? CMIN : v);
  endfunction

  // Expected result for one query under the current arc registers.
  function automatic result_t arc_closest(query_t q);
    longint cx, cy, sx, sy, ex, ey, qx, qy;
    longint v0x, v0y, v1x, v1y, dx, dy, vx, vy;
    longint rad, dl, ox, oy, clx, cly, nx, ny;
    bit     in0, in1, back, at_center;
    int     vert, s, dd;
    result_t r;
    cx = arc_reg[0]; cy = arc_reg[1];
    sx = arc_reg[2]; sy = arc_reg[3];
    ex = arc_reg[4]; ey = arc_reg[5];
    qx = q.query_x;  qy = q.query_y;
    v0x = sx - cx; v0y = sy - cy;
    v1x = ex - cx; v1y = ey - cy;
    dx = qx - cx;  dy = qy - cy;
    vx = ex - sx;  vy = ey - sy;
    at_center = (dx == 0) && (dy == 0);
    in0 = cross_sgn(dx, dy, v0x, v0y) * cross_sgn(vx, vy, v0x, v0y) <= 0;
    in1 = cross_sgn(dx, dy, v1x, v1y) * cross_sgn(vx, vy, v1x, v1y) >= 0;
    if (in0) vert = (in1 && dot_sgn(dx, dy, vx, vy) > 0) ? 1 : 0;
    else     vert = in1 ? 1 : -1;
    if (at_center) vert = 0;

    if (vert == 0) begin
      clx = sx; cly = sy;
    end else if (vert == 1) begin
      clx = ex; cly = ey;
    end else begin
      // Radial projection onto the circle through endpoint 0.
      rad = floor_root(v0x * v0x + v0y * v0y);
      dl  = floor_root(dx * dx + dy * dy);
      ox = 0; oy = 0;
      if (dl != 0) begin
        ox = ((dx < 0) ? -dx : dx) * rad / dl;
        oy = ((dy < 0) ? -dy : dy) * rad / dl;
        if (dx < 0) ox = -ox;
        if (dy < 0) oy = -oy;
      end
      clx = clamp_coord(cx + ox);
      cly = clamp_coord(cy + oy);
    end

    if (vert < 0) begin
      back = cross_sgn(clx - qx, cly - qy, vx, vy) > 0;
    end else begin
      nx = (vert == 1) ? v1x : v0x;
      ny = (vert == 1) ? v1y : v0y;
      s  = cross_sgn(nx, ny, vx, vy);
      dd = dot_sgn(clx - qx, cly - qy, nx, ny);
      back = (s < 0) ? (dd < 0) : (dd > 0);
    end

    r.closest_x  = coord_t'(clx);
    r.closest_y  = coord_t'(cly);
    r.region     = at_center ? REGION_CENTER :
                   (vert == 1) ? REGION_END : (vert == 0) ? REGION_START : REGION_ARC;
    r.backfacing = back;
    return r;
  endfunction

  // Driver: presents queued beats with a random gap before each one. In
  // burst mode the gaps vanish so back-to-back beats are exercised too.
  int gap_left = 0;
  bit send_burst = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      query_valid <= 1'b0;
    end else begin
      if (query_valid && !query_stall) begin
        closest_due.push_back(arc_closest(query));
        queries_sent++;
      end
      if (!query_valid || !query_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          query_valid <= 1'b0;
        end else if (query_backlog.size() > 0) begin
          query <= query_backlog.pop_front();
          query_valid <= 1'b1;
          if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
          gap_left = send_burst ? 0 : $urandom_range(0, 18);
        end else begin
          query_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result beat and draws the stall that
  // precedes the next one. Once, after 200 results, it holds off for a long
  // stretch so the pipeline fills and the block has to stall its input.
  int  hold_left = 0;
  bit  recv_burst = 1'b0;
  bit  long_hold_done = 1'b0;
  result_t want;
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (closest_due.size() == 0) begin
          $error("result beat with no query outstanding");
          fail_count++;
        end else begin
          want = closest_due.pop_front();
          if (result.closest_x !== want.closest_x) begin
            $error("closest_x: expected %0d, got %0d", want.closest_x, result.closest_x);
            fail_count++;
          end
          if (result.closest_y !== want.closest_y) begin
            $error("closest_y: expected %0d, got %0d", want.closest_y, result.closest_y);
            fail_count++;
          end
          if (result.region !== want.region) begin
            $error("region: expected %0d, got %0d", want.region, result.region);
            fail_count++;
          end
          if (result.backfacing !== want.backfacing) begin
            $error("backfacing: expected %0d, got %0d", want.backfacing, result.backfacing);
            fail_count++;
          end
          region_seen[want.region]++;
        end
        points_checked++;
        if (points_checked == 200 && !long_hold_done) begin
          long_hold_done = 1'b1;
          hold_left = 300;
        end else begin
          if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
          hold_left = recv_burst ? 0 : $urandom_range(0, 18);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("arc_closest_point_backface: mismatch");
      $finish;
    end
  end

  // Register writes happen only while the pipeline is empty.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[COORD_W-1:0];
    if (idx < 6) arc_reg[idx] = coord_t'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_arc(longint cx, longint cy, longint sx, longint sy,
                         longint ex, longint ey);
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_START_X, sx);
    write_reg(CFG_START_Y, sy);
    write_reg(CFG_END_X, ex);
    write_reg(CFG_END_Y, ey);
  endtask

  task automatic drain();
    while (query_backlog.size() != 0 || query_valid || closest_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic query_t make_query(longint qx, longint qy);
    query_t q;
    q.query_x = coord_t'(qx);
    q.query_y = coord_t'(qy);
    return q;
  endfunction

  // Random signed offset of random magnitude, so small and huge both occur.
  function automatic longint rand_offset();
    longint m;
    m = 64'sd1 << $urandom_range(0, 23);
    return longint'($urandom_range(0, 32'(2 * m))) - m;
  endfunction

  // Random query: mostly near the arc or the center, some anywhere.
  function automatic query_t rand_query();
    longint cx, cy;
    int     pick;
    cx = arc_reg[0]; cy = arc_reg[1];
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2: return make_query($urandom, $urandom);
      3, 4, 5, 6: return make_query(cx + rand_offset(), cy + rand_offset());
      7: return make_query(cx, cy);
      8: return make_query(longint'(arc_reg[2]) + rand_offset() / 64,
                           longint'(arc_reg[3]) + rand_offset() / 64);
      default: return make_query(longint'(arc_reg[4]) + rand_offset() / 64,
                                 longint'(arc_reg[5]) + rand_offset() / 64);
    endcase
  endfunction

  initial begin
    longint cx, cy, r;
    for (int i = 0; i < 6; i++) arc_reg[i] = '0;
    for (int i = 0; i < 4; i++) region_seen[i] = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset values: a fully degenerate arc, everything at the origin.
    query_backlog.push_back(make_query(0, 0));
    query_backlog.push_back(make_query(CMAX, CMIN));
    query_backlog.push_back(make_query(-256, 512));
    drain();

    // Quarter arc of radius 100 * 256 about the origin, with directed queries:
    // the center itself, each region, the endpoints and the coordinate
    // extremes (which push the interior projection far from the query).
    r = 100 * 256;
    set_arc(0, 0, r, 0, 0, r);
    query_backlog.push_back(make_query(0, 0));
    query_backlog.push_back(make_query(r, 0));
    query_backlog.push_back(make_query(0, r));
    query_backlog.push_back(make_query(r, r));
    query_backlog.push_back(make_query(r / 4, r / 4));
    query_backlog.push_back(make_query(2 * r, 0));
    query_backlog.push_back(make_query(r, -r));
    query_backlog.push_back(make_query(-r, r));
    query_backlog.push_back(make_query(-r, -r));
    query_backlog.push_back(make_query(CMAX, CMAX));
    query_backlog.push_back(make_query(CMIN, CMIN));
    query_backlog.push_back(make_query(CMAX, CMIN));
    query_backlog.push_back(make_query(CMIN, CMAX));
    query_backlog.push_back(make_query(1, 1));
    query_backlog.push_back(make_query(-1, 0));
    query_backlog.push_back(make_query(0, -1));
    drain();

    // Center off the origin: the query at the center takes the endpoint 0
    // backface rule. Writes to the unused indexes must leave the arc alone.
    set_arc(-5000, 7000, -5000 + 3000, 7000 - 4000, -5000 - 3000, 7000 - 4000);
    write_reg(3'd6, CMAX);
    write_reg(3'd7, CMIN);
    query_backlog.push_back(make_query(-5000, 7000));
    query_backlog.push_back(make_query(-5000, 0));
    query_backlog.push_back(make_query(-5000, 90000));
    drain();

    // Random phases: full-range arcs, extreme corners where the projection
    // saturates, small arcs, and collinear or coincident endpoints.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_arc(0, 0, 40000, 0, -40000, 0);
        1: set_arc(CMAX, CMAX, CMIN, CMIN, CMAX, CMIN);
        2: set_arc(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX);
        3: set_arc(1000, 1000, 1000, 1000, 1000, 1000);
        4: set_arc(300, -200, 300 + 5, -200, 300 + 5, -200);
        default: begin
          cx = longint'(coord_t'($urandom));
          cy = longint'(coord_t'($urandom));
          if (ph == 7) set_arc(cx, cy, $urandom, $urandom, $urandom, $urandom);
          else set_arc(cx, cy, cx + rand_offset(), cy + rand_offset(),
                       cx + rand_offset(), cy + rand_offset());
        end
      endcase
      for (int n = 0; n < 165; n++) query_backlog.push_back(rand_query());
      drain();
    end

    $display("Checked %0d results from %0d queries over 11 arc settings.",
             points_checked, queries_sent);
    $display("Regions seen: start %0d, end %0d, interior %0d, center %0d.",
             region_seen[0], region_seen[1], region_seen[2], region_seen[3]);
    if (fail_count == 0 && closest_due.size() == 0) begin
      $display("arc_closest_point_backface: match");
    end else begin
      $display("arc_closest_point_backface: mismatch");
    end
    $finish;
  end

endmodule
